>>> design/atis_pkg.sv
// ----------------------------------------------------------------------------
// Autotile index select package
// Shared widths, register indexes and autotile constants.
// ----------------------------------------------------------------------------
`default_nettype none

package atis_pkg;

  localparam int unsigned BASE_W = 14;
  localparam int unsigned TILE_W = 15;
  localparam int unsigned OFS_W  = 6;

  // Configuration register indexes.
  localparam logic CFG_WALL_BASE  = 1'b0;
  localparam logic CFG_FLOOR_BASE = 1'b1;

  // Bases inside this window get an autotile offset.
  localparam logic [BASE_W-1:0] AT_LOW  = BASE_W'(4000);
  localparam logic [BASE_W-1:0] AT_HIGH = BASE_W'(4550);

  // First offset of each group, by the number of open edges.
  localparam logic [OFS_W-1:0] OFS_ONE_EDGE   = OFS_W'(1 << 4);
  localparam logic [OFS_W-1:0] OFS_TWO_EDGE   = OFS_W'((1 << 4) + 16);
  localparam logic [OFS_W-1:0] OFS_THREE_EDGE = OFS_W'((1 << 4) + 26);
  localparam logic [OFS_W-1:0] OFS_FOUR_EDGE  = OFS_W'((1 << 4) + 30);

  // Upper bound on the tile id: the largest base plus the largest offset.
  localparam logic [TILE_W-1:0] TILE_MAX = TILE_W'((1 << BASE_W) - 1 + 46);

endpackage : atis_pkg

`default_nettype wire

>>> design/atis_in_if.sv
// ----------------------------------------------------------------------------
// Autotile index select input channel
// Valid/ready channel carrying the open bits of one cell and its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

interface atis_in_if;
  logic valid;
  logic ready;
  logic center_open;
  logic left_open;
  logic up_open;
  logic right_open;
  logic down_open;
  logic up_left_open;
  logic up_right_open;
  logic down_right_open;
  logic down_left_open;

  modport source (
    output valid, center_open, left_open, up_open, right_open, down_open,
           up_left_open, up_right_open, down_right_open, down_left_open,
    input  ready
  );

  modport sink (
    input  valid, center_open, left_open, up_open, right_open, down_open,
           up_left_open, up_right_open, down_right_open, down_left_open,
    output ready
  );
endinterface : atis_in_if

`default_nettype wire

>>> design/atis_out_if.sv
// ----------------------------------------------------------------------------
// Autotile index select result channel
// Valid/ready channel carrying one chosen tile id.
// ----------------------------------------------------------------------------
`default_nettype none

interface atis_out_if
  import atis_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [TILE_W-1:0] tile_id;

  modport source (
    output valid, tile_id,
    input  ready
  );

  modport sink (
    input  valid, tile_id,
    output ready
  );
endinterface : atis_out_if

`default_nettype wire

>>> design/autotile_index_select_core.sv
// ----------------------------------------------------------------------------
// Autotile index select core
// Maps the open/solid neighborhood of one map cell to a tile id.
// ----------------------------------------------------------------------------
// One cell is accepted per cycle while the result side keeps up. A transaction
// is captured in an input register, its tile id is formed by a single pass of
// logic (base select, window compare, neighbor offset and one 15-bit add) and
// held in the result register, so each result passes the input register and
// then the result register, and the block sustains one cell per clock while
// the result side keeps taking them. Both registers stall in place under
// backpressure. The wall and floor bases are written through the cfg_ port
// and reset to zero; write them only while no transaction is in flight.
`default_nettype none

module autotile_index_select_core
  import atis_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  atis_in_if.sink                in_chan,
  atis_out_if.source             out_chan,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [BASE_W-1:0] cfg_wdata
);

  logic [BASE_W-1:0] wall_base_r;
  logic [BASE_W-1:0] floor_base_r;

  // Input register stage.
  logic       s1_valid_r;
  logic       c_r, lf_r, up_r, rt_r, dn_r, lu_r, ru_r, rd_r, ld_r;
  logic       s1_ready;

  // Result register stage.
  logic              out_valid_r;
  logic [TILE_W-1:0] tile_r;
  logic [TILE_W-1:0] tile_nxt;
  logic              s2_ready;

  logic [BASE_W-1:0] base;
  logic [OFS_W-1:0]  ofs;
  logic [2:0]        edge_cnt;
  logic              in_window;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_base_r  <= '0;
      floor_base_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WALL_BASE:  wall_base_r  <= cfg_wdata;
        CFG_FLOOR_BASE: floor_base_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s2_ready      = !out_valid_r || out_chan.ready;
  assign s1_ready      = !s1_valid_r || s2_ready;
  assign in_chan.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_chan.valid) begin
      c_r  <= in_chan.center_open;
      lf_r <= in_chan.left_open;
      up_r <= in_chan.up_open;
      rt_r <= in_chan.right_open;
      dn_r <= in_chan.down_open;
      lu_r <= in_chan.up_left_open;
      ru_r <= in_chan.up_right_open;
      rd_r <= in_chan.down_right_open;
      ld_r <= in_chan.down_left_open;
    end
  end

  assign edge_cnt = 3'(lf_r) + 3'(up_r) + 3'(rt_r) + 3'(dn_r);

  always_comb begin
    ofs = '0;
    unique case (edge_cnt)
      3'd0: ofs = {2'b00, ld_r, rd_r, ru_r, lu_r};
      3'd1: begin
        // The two corners away from the open edge select within the group.
        priority if (lf_r) ofs = OFS_ONE_EDGE + OFS_W'({rd_r, ru_r});
        else if (up_r)     ofs = OFS_ONE_EDGE + OFS_W'(4) + OFS_W'({ld_r, rd_r});
        else if (rt_r)     ofs = OFS_ONE_EDGE + OFS_W'(8) + OFS_W'({lu_r, ld_r});
        else               ofs = OFS_ONE_EDGE + OFS_W'(12) + OFS_W'({ru_r, lu_r});
      end
      3'd2: begin
        priority if (lf_r && rt_r) ofs = OFS_TWO_EDGE;
        else if (up_r && dn_r)     ofs = OFS_TWO_EDGE + OFS_W'(1);
        else if (up_r && lf_r)     ofs = OFS_TWO_EDGE + OFS_W'(2) + OFS_W'(rd_r);
        else if (up_r)             ofs = OFS_TWO_EDGE + OFS_W'(4) + OFS_W'(ld_r);
        else if (rt_r)             ofs = OFS_TWO_EDGE + OFS_W'(6) + OFS_W'(lu_r);
        else                       ofs = OFS_TWO_EDGE + OFS_W'(8) + OFS_W'(ru_r);
      end
      3'd3: begin
        priority if (!dn_r) ofs = OFS_THREE_EDGE;
        else if (!rt_r)     ofs = OFS_THREE_EDGE + OFS_W'(1);
        else if (!up_r)     ofs = OFS_THREE_EDGE + OFS_W'(2);
        else                ofs = OFS_THREE_EDGE + OFS_W'(3);
      end
      default: ofs = OFS_FOUR_EDGE;
    endcase
  end

  assign base      = c_r ? floor_base_r : wall_base_r;
  assign in_window = (base >= AT_LOW) && (base <= AT_HIGH);
  assign tile_nxt  = TILE_W'(base) + (in_window ? TILE_W'(ofs) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      tile_r <= tile_nxt;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.tile_id = tile_r;

  // An accepted transaction always lands in the input stage.
  a_accept_fills_s1 : assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> s1_valid_r)
    else $error("accepted transaction did not reach the input stage");

  // A held input stage is not dropped while the result side stalls.
  a_s1_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_ready) |=> (s1_valid_r && $stable(lf_r) && $stable(c_r)))
    else $error("input stage lost its transaction during a stall");

  // An advancing input stage produces a result in the next cycle.
  a_s1_to_out : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_ready) |=> out_valid_r)
    else $error("input stage advanced without producing a result");

  // Results never exceed the largest base plus the largest offset.
  a_tile_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (tile_r <= TILE_MAX))
    else $error("tile id out of range");

endmodule : autotile_index_select_core

`default_nettype wire

>>> tb/autotile_index_select_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Autotile index select checker
// Watches the cell and tile channels and the register port, predicts the
// tile id of every accepted cell and compares it with the result channel.
// ----------------------------------------------------------------------------

module autotile_index_select_checker
  import atis_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  atis_in_if                     in_mon,
  atis_out_if                    out_mon,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [BASE_W-1:0] cfg_wdata,
  output int unsigned            fail_count,
  output int unsigned            pending_count
);

  typedef struct packed {
    logic center;
    logic left;
    logic up;
    logic right;
    logic down;
    logic up_left;
    logic up_right;
    logic down_right;
    logic down_left;
  } cell_t;

  logic [BASE_W-1:0] wall_base;
  logic [BASE_W-1:0] floor_base;
  logic [TILE_W-1:0] tile_id_q[$];
  logic [TILE_W-1:0] want_tile;
  cell_t             seen_cell;

  function automatic logic [OFS_W-1:0] neighbor_offset(input cell_t c);
    int edges;
    int ofs;
    edges = int'(c.left) + int'(c.up) + int'(c.right) + int'(c.down);
    case (edges)
      0: begin
        ofs = int'(c.up_left) + 2 * int'(c.up_right) + 4 * int'(c.down_right)
            + 8 * int'(c.down_left);
      end
      1: begin
        // The two corners that face away from the single open edge.
        if (c.left) begin
          ofs = int'(OFS_ONE_EDGE) + int'(c.up_right) + 2 * int'(c.down_right);
        end else if (c.up) begin
          ofs = int'(OFS_ONE_EDGE) + 4 + int'(c.down_right) + 2 * int'(c.down_left);
        end else if (c.right) begin
          ofs = int'(OFS_ONE_EDGE) + 8 + int'(c.down_left) + 2 * int'(c.up_left);
        end else begin
          ofs = int'(OFS_ONE_EDGE) + 12 + int'(c.up_left) + 2 * int'(c.up_right);
        end
      end
      2: begin
        if (c.left && c.right) begin
          ofs = int'(OFS_TWO_EDGE);
        end else if (c.up && c.down) begin
          ofs = int'(OFS_TWO_EDGE) + 1;
        end else if (c.up && c.left) begin
          ofs = int'(OFS_TWO_EDGE) + 2 + int'(c.down_right);
        end else if (c.up) begin
          ofs = int'(OFS_TWO_EDGE) + 4 + int'(c.down_left);
        end else if (c.right) begin
          ofs = int'(OFS_TWO_EDGE) + 6 + int'(c.up_left);
        end else begin
          ofs = int'(OFS_TWO_EDGE) + 8 + int'(c.up_right);
        end
      end
      3: begin
        if (!c.down) begin
          ofs = int'(OFS_THREE_EDGE);
        end else if (!c.right) begin
          ofs = int'(OFS_THREE_EDGE) + 1;
        end else if (!c.up) begin
          ofs = int'(OFS_THREE_EDGE) + 2;
        end else begin
          ofs = int'(OFS_THREE_EDGE) + 3;
        end
      end
      default: begin
        ofs = int'(OFS_FOUR_EDGE);
      end
    endcase
    return OFS_W'(ofs);
  endfunction

  function automatic logic [TILE_W-1:0] predict_tile_id(input cell_t c);
    logic [BASE_W-1:0] base;
    logic [TILE_W-1:0] tile;
    base = c.center ? floor_base : wall_base;
    tile = TILE_W'(base);
    if (base >= AT_LOW && base <= AT_HIGH) begin
      tile = tile + TILE_W'(neighbor_offset(c));
    end
    return tile;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] tile check: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      wall_base     = '0;
      floor_base    = '0;
      tile_id_q.delete();
      pending_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WALL_BASE:  wall_base  = cfg_wdata;
          CFG_FLOOR_BASE: floor_base = cfg_wdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        seen_cell = '{center: in_mon.center_open, left: in_mon.left_open,
                      up: in_mon.up_open, right: in_mon.right_open,
                      down: in_mon.down_open, up_left: in_mon.up_left_open,
                      up_right: in_mon.up_right_open,
                      down_right: in_mon.down_right_open,
                      down_left: in_mon.down_left_open};
        tile_id_q = {tile_id_q, predict_tile_id(seen_cell)};
      end
      if (out_mon.valid && out_mon.ready) begin
        if (tile_id_q.size() == 0) begin
          report_mismatch($sformatf("tile id %0d with no cell waiting", out_mon.tile_id));
        end else begin
          want_tile = tile_id_q.pop_front();
          if (out_mon.tile_id !== want_tile) begin
            report_mismatch($sformatf("tile id %0d, predicted %0d",
                                      out_mon.tile_id, want_tile));
          end
        end
      end
      pending_count = tile_id_q.size();
    end
  end

endmodule : autotile_index_select_checker

>>> tb/tb_autotile_index_select_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Autotile index select core testbench
// Drives cells through the core under several wall and floor base settings
// and gap patterns; the checker beside the core predicts every tile id.
// ----------------------------------------------------------------------------

module tb_autotile_index_select_core
  import atis_pkg::*;
;

  typedef struct packed {
    logic center;
    logic left;
    logic up;
    logic right;
    logic down;
    logic up_left;
    logic up_right;
    logic down_right;
    logic down_left;
  } nbhd_t;

  typedef enum int {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} gap_mode_t;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned NUM_DIRECTED = 19;

  // Order: center, left, up, right, down, up-left, up-right, down-right,
  // down-left. One cell per offset group and corner pattern of interest.
  localparam logic [8:0] DIRECTED_CELLS [NUM_DIRECTED] = '{
    9'b0_0000_0000, 9'b1_1111_1111, 9'b0_0000_1111, 9'b1_0000_0101,
    9'b0_1000_0110, 9'b1_0100_0011, 9'b0_0010_1001, 9'b1_0001_1100,
    9'b0_1010_1111, 9'b1_0101_0000, 9'b0_1100_0010, 9'b1_0110_0001,
    9'b0_0011_1000, 9'b1_1001_0100, 9'b0_1110_0000, 9'b1_1101_1111,
    9'b0_1011_0000, 9'b1_0111_0000, 9'b0_1111_0000
  };

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic              cfg_index;
  logic [BASE_W-1:0] cfg_wdata;
  int unsigned       fail_count;
  int unsigned       pending_count;
  int unsigned       cycle_count = 0;
  int unsigned       cells_sent = 0;
  int unsigned       settings_used = 0;
  int unsigned       held_cycles = 0;
  logic              hold_armed;
  gap_mode_t         gap_mode;

  atis_in_if  in_chan ();
  atis_out_if out_chan ();

  autotile_index_select_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  autotile_index_select_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic bit roll(input int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int unsigned send_gap_pct(input gap_mode_t m);
    case (m)
      GAP_SEND: return 48;
      GAP_BOTH: return 28;
      default:  return 0;
    endcase
  endfunction

  function automatic int unsigned recv_stall_pct(input gap_mode_t m);
    case (m)
      GAP_RECV: return 48;
      GAP_BOTH: return 28;
      default:  return 0;
    endcase
  endfunction

  // The long hold-off is counted here so the sender keeps offering cells
  // against a full core.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_armed && held_cycles < HOLD_CYCLES) begin
      out_chan.ready <= 1'b0;
      held_cycles    <= held_cycles + 1;
    end else begin
      out_chan.ready <= !roll(recv_stall_pct(gap_mode));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tile ids outstanding",
               cycle_count, pending_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Entered at a falling edge; returns at the falling edge after the
  // transaction, with valid still high for the caller to reuse or drop.
  task automatic send_cell(input nbhd_t c);
    while (roll(send_gap_pct(gap_mode))) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid           <= 1'b1;
    in_chan.center_open     <= c.center;
    in_chan.left_open       <= c.left;
    in_chan.up_open         <= c.up;
    in_chan.right_open      <= c.right;
    in_chan.down_open       <= c.down;
    in_chan.up_left_open    <= c.up_left;
    in_chan.up_right_open   <= c.up_right;
    in_chan.down_right_open <= c.down_right;
    in_chan.down_left_open  <= c.down_left;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    cells_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_cells(input int unsigned n);
    repeat (n) send_cell(nbhd_t'($urandom_range(0, 511)));
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [BASE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_bases(input logic [BASE_W-1:0] wall, input logic [BASE_W-1:0] floor_b);
    write_reg(CFG_WALL_BASE, wall);
    write_reg(CFG_FLOOR_BASE, floor_b);
    settings_used++;
  endtask

  task automatic run_phase(input logic [BASE_W-1:0] wall, input logic [BASE_W-1:0] floor_b,
                           input gap_mode_t m, input int unsigned n);
    set_bases(wall, floor_b);
    gap_mode = m;
    send_random_cells(n);
    drain();
  endtask

  initial begin
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_index               = CFG_WALL_BASE;
    cfg_wdata               = '0;
    hold_armed              = 1'b0;
    gap_mode                = GAP_NONE;
    out_chan.ready          = 1'b0;
    in_chan.valid           = 1'b0;
    in_chan.center_open     = 1'b0;
    in_chan.left_open       = 1'b0;
    in_chan.up_open         = 1'b0;
    in_chan.right_open      = 1'b0;
    in_chan.down_open       = 1'b0;
    in_chan.up_left_open    = 1'b0;
    in_chan.up_right_open   = 1'b0;
    in_chan.down_right_open = 1'b0;
    in_chan.down_left_open  = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Both bases still at their reset value of zero.
    settings_used++;
    send_random_cells(60);
    drain();

    // Window edges as bases, then every offset group by hand.
    set_bases(AT_LOW, AT_HIGH);
    gap_mode = GAP_NONE;
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_cell(nbhd_t'(DIRECTED_CELLS[i]));
    end
    send_random_cells(200);
    drain();

    run_phase(BASE_W'(16383), BASE_W'(0), GAP_SEND, 150);
    run_phase(BASE_W'(AT_LOW - 1), BASE_W'(AT_HIGH + 1), GAP_RECV, 150);
    run_phase(BASE_W'($urandom_range(4000, 4550)), BASE_W'($urandom_range(4000, 4550)),
              GAP_BOTH, 300);

    // Result side held off long enough for the core to fill and stall.
    set_bases(AT_HIGH, AT_LOW);
    gap_mode   = GAP_NONE;
    hold_armed = 1'b1;
    send_random_cells(200);
    drain();

    run_phase(BASE_W'($urandom_range(0, 16383)), BASE_W'($urandom_range(4000, 4550)),
              GAP_SEND, 250);
    run_phase(BASE_W'($urandom_range(4000, 4550)), BASE_W'($urandom_range(0, 16383)),
              GAP_RECV, 250);
    run_phase(BASE_W'($urandom_range(4000, 4550)), BASE_W'($urandom_range(4000, 4550)),
              GAP_BOTH, 250);

    repeat (10) @(posedge clk);
    $display("Sent %0d cells under %0d base settings, window edges and all offset groups,",
             cells_sent, settings_used);
    $display("with sender gaps, result stalls and one long result hold-off; %0d failures.",
             fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule : tb_autotile_index_select_core

>>> files.f
design/atis_pkg.sv
design/atis_in_if.sv
design/atis_out_if.sv
design/autotile_index_select_core.sv
tb/autotile_index_select_checker.sv
tb/tb_autotile_index_select_core.sv
